FILE: src/pinhole_projection_jacobian_assert.svh
// ----------------------------------------------------------------------------
// Pinhole projection assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_PROJECTION_JACOBIAN_ASSERT_SVH
`define PINHOLE_PROJECTION_JACOBIAN_ASSERT_SVH

`ifndef ASSERT_OFF
`define PJAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PJAC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PJAC_ASSERT(label, prop, msg)
`define PJAC_NEVER(label, expr, msg)
`endif

`endif

FILE: src/pjac_pkg.sv
// ----------------------------------------------------------------------------
// Pinhole projection package
// Shared widths, codes and types of the projection pipeline.
// ----------------------------------------------------------------------------
package pjac_pkg;

  localparam int FRAC_BITS = 16;
  // Quotient bits kept; anything at or above 2^40 saturates anyway.
  localparam int QBITS     = 41;
  localparam int NUM_W     = 64 + FRAC_BITS;
  localparam int DEN_W     = 64;
  localparam int SUM_W     = QBITS + 3;
  localparam int DIV_LAT   = QBITS + 2;
  localparam int PIPE_LAT  = QBITS + 6;
  localparam int NUM_DIV   = 6;
  localparam logic [QBITS-1:0] MAG_CAP = {1'b1, {(QBITS-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_FOCAL_X  = 2'd0,
    REG_FOCAL_Y  = 2'd1,
    REG_CENTER_X = 2'd2,
    REG_CENTER_Y = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic               zero;
    logic [NUM_DIV-1:0] neg;
  } side_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } fin_t;

endpackage

FILE: src/pjac_div.sv
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Restoring division, one quotient bit per stage, with overflow and round bit.
// ----------------------------------------------------------------------------
module pjac_div import pjac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             valid_o,
  output logic [QBITS-1:0] quot_o,
  output logic             ovf_o,
  output logic             rnd_o
);

  logic [DEN_W-1:0] rem_q [QBITS+1];
  logic [QBITS-1:0] sh_q  [QBITS+1];
  logic [DEN_W-1:0] den_q [QBITS+1];
  logic             ovf_q [QBITS+1];
  logic [QBITS:0]   vld_q;
  logic             valid_q, ovf_out_q, rnd_q;
  logic [QBITS-1:0] quot_q;

  // The quotient fits in QBITS bits only when the high numerator part is below d.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= DEN_W'(num_i[NUM_W-1:QBITS]);
    sh_q[0]  <= num_i[QBITS-1:0];
    den_q[0] <= den_i;
    ovf_q[0] <= (DEN_W'(num_i[NUM_W-1:QBITS]) >= den_i);
  end

  for (genvar i = 1; i <= QBITS; i++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    logic [DEN_W:0] diff;

    assign trial = {rem_q[i-1], sh_q[i-1][QBITS-1]};
    assign ge    = (trial >= {1'b0, den_q[i-1]});
    assign diff  = trial - {1'b0, den_q[i-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_q[i]  <= {sh_q[i-1][QBITS-2:0], ge};
      den_q[i] <= den_q[i-1];
      ovf_q[i] <= ovf_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[QBITS];
    end
  end

  // Round half away from zero: bump when the remainder is at least half of d.
  always_ff @(posedge clk_i) begin
    quot_q    <= sh_q[QBITS];
    ovf_out_q <= ovf_q[QBITS];
    rnd_q     <= (rem_q[QBITS] >= (den_q[QBITS] - rem_q[QBITS]));
  end

  assign valid_o = valid_q;
  assign quot_o  = quot_q;
  assign ovf_o   = ovf_out_q;
  assign rnd_o   = rnd_q;

endmodule

FILE: src/pinhole_projection_jacobian.sv
// ----------------------------------------------------------------------------
// Pinhole projection with Jacobian
// A request passes stage 1, stage 2, the dividers, stage F1 and the output register.
// Throughput: one request per cycle; busy is never raised and the receiver cannot stall.
// Depth is set by the 41 one-bit stages of the pipelined dividers.
// Reset clears the valid chain and loads the default intrinsics.
// ----------------------------------------------------------------------------
`include "pinhole_projection_jacobian_assert.svh"

module pinhole_projection_jacobian import pjac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               result_valid_o,
  output logic signed [31:0] image_u_o,
  output logic signed [31:0] image_v_o,
  output logic signed [31:0] du_dx_o,
  output logic signed [31:0] du_dz_o,
  output logic signed [31:0] dv_dy_o,
  output logic signed [31:0] dv_dz_o,
  output logic [1:0]         status_o
);

  logic [31:0] fx_q, fy_q, cx_q, cy_q;
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign widx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= 32'd32768000;
      fy_q <= 32'd32768000;
      cx_q <= 32'd20971520;
      cy_q <= 32'd15728640;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_FOCAL_X:  fx_q <= pwdata;
        REG_FOCAL_Y:  fy_q <= pwdata;
        REG_CENTER_X: cx_q <= pwdata;
        REG_CENTER_Y: cy_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_FOCAL_X:  prdata = fx_q;
      REG_FOCAL_Y:  prdata = fy_q;
      REG_CENTER_X: prdata = cx_q;
      REG_CENTER_Y: prdata = cy_q;
      default:      prdata = 32'd0;
    endcase
  end

  // Stage 1: magnitudes and signs.
  logic        s1_valid_q;
  logic [31:0] s1_ax_q, s1_ay_q, s1_az_q;
  side_t       s1_side_q;
  logic        xneg, yneg, zneg, xpos, ypos;

  assign xneg = point_x_i[31];
  assign yneg = point_y_i[31];
  assign zneg = point_z_i[31];
  assign xpos = !xneg && (point_x_i != 32'sd0);
  assign ypos = !yneg && (point_y_i != 32'sd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ax_q        <= xneg ? (~point_x_i + 32'd1) : point_x_i;
    s1_ay_q        <= yneg ? (~point_y_i + 32'd1) : point_y_i;
    s1_az_q        <= zneg ? (~point_z_i + 32'd1) : point_z_i;
    s1_side_q.zero <= (point_z_i == 32'sd0);
    s1_side_q.neg  <= {ypos, zneg, yneg ^ zneg, xpos, zneg, xneg ^ zneg};
  end

  // Stage 2: focal products and squared depth.
  logic        s2_valid_q;
  logic [63:0] s2_px_q, s2_py_q, s2_zz_q;
  logic [31:0] s2_az_q;
  side_t       s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_px_q   <= {32'd0, fx_q} * {32'd0, s1_ax_q};
    s2_py_q   <= {32'd0, fy_q} * {32'd0, s1_ay_q};
    s2_zz_q   <= {32'd0, s1_az_q} * {32'd0, s1_az_q};
    s2_az_q   <= s1_az_q;
    s2_side_q <= s1_side_q;
  end

  // Division order: u, du/dx, du/dz, v, dv/dy, dv/dz.
  logic [NUM_W-1:0] num [NUM_DIV];
  logic [DEN_W-1:0] den [NUM_DIV];
  logic [QBITS-1:0] quot [NUM_DIV];
  logic             ovf  [NUM_DIV];
  logic             rnd  [NUM_DIV];
  logic             div_valid;

  assign num[0] = NUM_W'(s2_px_q);
  assign num[1] = NUM_W'({fx_q, {FRAC_BITS{1'b0}}});
  assign num[2] = {s2_px_q, {FRAC_BITS{1'b0}}};
  assign num[3] = NUM_W'(s2_py_q);
  assign num[4] = NUM_W'({fy_q, {FRAC_BITS{1'b0}}});
  assign num[5] = {s2_py_q, {FRAC_BITS{1'b0}}};
  assign den[0] = DEN_W'(s2_az_q);
  assign den[1] = DEN_W'(s2_az_q);
  assign den[2] = s2_zz_q;
  assign den[3] = DEN_W'(s2_az_q);
  assign den[4] = DEN_W'(s2_az_q);
  assign den[5] = s2_zz_q;

  for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
    if (k == 0) begin : g_lead
      pjac_div u_div (
        .clk_i, .rst_ni, .valid_i(s2_valid_q), .num_i(num[k]), .den_i(den[k]),
        .valid_o(div_valid), .quot_o(quot[k]), .ovf_o(ovf[k]), .rnd_o(rnd[k])
      );
    end else begin : g_rest
      pjac_div u_div (
        .clk_i, .rst_ni, .valid_i(s2_valid_q), .num_i(num[k]), .den_i(den[k]),
        .valid_o(), .quot_o(quot[k]), .ovf_o(ovf[k]), .rnd_o(rnd[k])
      );
    end
  end

  side_t side_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    side_q[0] <= s2_side_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // Stage F1: rounded magnitude, capped.
  logic             f1_valid_q;
  logic [QBITS-1:0] f1_mag_q [NUM_DIV];
  side_t            f1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_DIV; k++) begin
      f1_mag_q[k] <= (ovf[k] || quot[k][QBITS-1]) ? MAG_CAP : (quot[k] + QBITS'(rnd[k]));
    end
    f1_side_q <= side_q[DIV_LAT-1];
  end

  function automatic fin_t finish(logic [QBITS-1:0] mag, logic neg, logic [31:0] off);
    logic signed [SUM_W-1:0] s;
    fin_t                    r;
    s = neg ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
    s = s + $signed(SUM_W'(off));
    // Out of range when the bits above bit 31 are not all copies of the sign.
    if ((s[SUM_W-1:31] != '0) && (s[SUM_W-1:31] != '1)) begin
      r.sat = 1'b1;
      r.val = s[SUM_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r.sat = 1'b0;
      r.val = s[31:0];
    end
    return r;
  endfunction

  fin_t        fin [NUM_DIV];
  logic [31:0] offs [NUM_DIV];
  logic        any_sat;

  assign offs[0] = cx_q;
  assign offs[1] = 32'd0;
  assign offs[2] = 32'd0;
  assign offs[3] = cy_q;
  assign offs[4] = 32'd0;
  assign offs[5] = 32'd0;

  always_comb begin
    any_sat = 1'b0;
    for (int k = 0; k < NUM_DIV; k++) begin
      fin[k]  = finish(f1_mag_q[k], f1_side_q.neg[k], offs[k]);
      any_sat = any_sat | fin[k].sat;
    end
  end

  logic        out_valid_q;
  logic [31:0] out_val_q [NUM_DIV];
  status_e     out_status_q;
  logic        out_vals_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_DIV; k++) begin
      out_val_q[k] <= f1_side_q.zero ? 32'd0 : fin[k].val;
    end
    if (f1_side_q.zero) begin
      out_status_q <= ST_ZERO;
    end else begin
      out_status_q <= any_sat ? ST_SAT : ST_OK;
    end
  end

  assign out_vals_zero = (out_val_q[0] == 32'd0) && (out_val_q[1] == 32'd0) &&
                         (out_val_q[2] == 32'd0) && (out_val_q[3] == 32'd0) &&
                         (out_val_q[4] == 32'd0) && (out_val_q[5] == 32'd0);

  assign result_valid_o = out_valid_q;
  assign image_u_o      = $signed(out_val_q[0]);
  assign du_dx_o        = $signed(out_val_q[1]);
  assign du_dz_o        = $signed(out_val_q[2]);
  assign image_v_o      = $signed(out_val_q[3]);
  assign dv_dy_o        = $signed(out_val_q[4]);
  assign dv_dz_o        = $signed(out_val_q[5]);
  assign status_o       = out_status_q;

  `PJAC_ASSERT(a_latency, start |-> ##(PIPE_LAT) result_valid_o, "result strobe missing")
  `PJAC_ASSERT(a_zero_clear, (result_valid_o && status_o == ST_ZERO) |-> out_vals_zero, "zero depth result not cleared")
  `PJAC_ASSERT(a_no_orphan, result_valid_o |-> $past(f1_valid_q), "result strobe without request")
  `PJAC_NEVER(a_status_code, result_valid_o && status_o == 2'd3, "undefined status code")

endmodule
